// File: rtl/m3inv_pkg.sv
// ----------------------------------------------------------------------------
// m3inv_pkg: shared types and constants for the 3x3 matrix inverse
// Widths of the cofactor, determinant and divider datapaths.
// ----------------------------------------------------------------------------
package m3inv_pkg;

  localparam int ELEM_W = 32;
  localparam int ADJ_W  = 65;   // exact cofactor: difference of two 64b products
  localparam int DET_W  = 98;   // exact determinant, scale 2^48
  localparam int MAG_W  = 97;   // |det|
  localparam int NUM_W  = 97;   // |cofactor| << 32
  localparam int QBITS  = 33;   // quotient bits kept before saturation

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [ADJ_W-1:0]  adj_t;
  typedef logic signed [DET_W-1:0]  det_t;

  typedef struct packed {
    logic [8:0] neg;     // result sign per element
    logic       sing;    // determinant is zero
  } ctl_t;

endpackage

// File: rtl/m3inv_cof.sv
// ----------------------------------------------------------------------------
// m3inv_cof: cofactor and determinant stages
// Stage 1 forms the 64b products, stage 2 the cofactors, stages 3 and 4 the
// three determinant terms from 32 x 33 partial products, stage 5 their sum,
// stage 6 the magnitudes and signs.
// ----------------------------------------------------------------------------
module m3inv_cof
  import m3inv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vin,
  input  elem_t [8:0]          m,
  output logic                 vout,
  output logic [MAG_W-1:0]     dmag,
  output logic [63:0]          amag [9],
  output ctl_t                 ctl
);

  // product pairs per cofactor: adj = p[2i] - p[2i+1]
  logic signed [63:0] p_r [18];
  logic signed [63:0] p_nxt [18];
  adj_t               adj_r [9];
  // cofactors delayed to line up with the determinant
  adj_t               adjd_r [3][9];
  elem_t              a_r, b_r, c_r, a2_r, b2_r, c2_r;
  elem_t              x_s [3];
  adj_t               y_s [3];
  logic signed [64:0] pl_r [3];
  logic signed [64:0] ph_r [3];
  logic signed [96:0] dp_r [3];
  det_t               det_s, det_r;
  logic [5:0]         v_r;

  always_comb begin
    p_nxt[0]  = m[4]*m[8]; p_nxt[1]  = m[5]*m[7];
    p_nxt[2]  = m[2]*m[7]; p_nxt[3]  = m[1]*m[8];
    p_nxt[4]  = m[1]*m[5]; p_nxt[5]  = m[2]*m[4];
    p_nxt[6]  = m[5]*m[6]; p_nxt[7]  = m[3]*m[8];
    p_nxt[8]  = m[0]*m[8]; p_nxt[9]  = m[2]*m[6];
    p_nxt[10] = m[2]*m[3]; p_nxt[11] = m[0]*m[5];
    p_nxt[12] = m[3]*m[7]; p_nxt[13] = m[4]*m[6];
    p_nxt[14] = m[6]*m[1]; p_nxt[15] = m[0]*m[7];
    p_nxt[16] = m[0]*m[4]; p_nxt[17] = m[1]*m[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], vin};
    end
  end

  // first-row elements against their cofactors
  always_comb begin
    x_s[0] = a2_r; x_s[1] = b2_r; x_s[2] = c2_r;
    y_s[0] = adj_r[0]; y_s[1] = adj_r[3]; y_s[2] = adj_r[6];
  end

  always_comb begin
    det_s = DET_W'(dp_r[0]) + DET_W'(dp_r[1]) + DET_W'(dp_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 18; i++) p_r[i] <= p_nxt[i];
      a_r <= m[0]; b_r <= m[1]; c_r <= m[2];
      for (int i = 0; i < 9; i++) adj_r[i] <= ADJ_W'(p_r[2*i]) - ADJ_W'(p_r[2*i+1]);
      a2_r <= a_r; b2_r <= b_r; c2_r <= c_r;
      // cofactor split into a low unsigned and a high signed half;
      // operands are sign-extended, so each multiplier is 32 x 33
      for (int j = 0; j < 3; j++) begin
        pl_r[j] <= 65'(x_s[j]) * 65'($signed({1'b0, y_s[j][31:0]}));
        ph_r[j] <= 65'(x_s[j]) * 65'($signed(y_s[j][ADJ_W-1:32]));
        dp_r[j] <= (97'(ph_r[j]) <<< 32) + 97'(pl_r[j]);
      end
      det_r    <= det_s;
      dmag     <= det_r[DET_W-1] ? MAG_W'(-det_r) : MAG_W'(det_r);
      ctl.sing <= (det_r == '0);
      for (int i = 0; i < 9; i++) begin
        adjd_r[0][i] <= adj_r[i];
        adjd_r[1][i] <= adjd_r[0][i];
        adjd_r[2][i] <= adjd_r[1][i];
        amag[i]    <= adjd_r[2][i][ADJ_W-1] ? 64'(-adjd_r[2][i]) : 64'(adjd_r[2][i]);
        ctl.neg[i] <= adjd_r[2][i][ADJ_W-1] ^ det_r[DET_W-1];
      end
    end
  end

  assign vout = v_r[5];

endmodule

// File: rtl/m3inv_div.sv
// ----------------------------------------------------------------------------
// m3inv_div: pipelined restoring divider, one quotient bit per stage
// Only the low QBITS quotient bits plus an overflow flag are tracked.
// ----------------------------------------------------------------------------
module m3inv_div
  import m3inv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vin,
  input  logic [MAG_W-1:0]  den,
  input  logic [63:0]       amag,
  input  logic              neg,
  input  logic              sing,
  output logic              vout,
  output elem_t             q,
  output logic              sat
);

  localparam int REM_W = MAG_W + 1;

  // Quotient bits above QBITS-1 are nonzero iff (amag<<32) >= den<<QBITS,
  // i.e. amag >= den << 1 (since QBITS = 33). Checked in the first stage.
  logic [REM_W-1:0] rem_r [QBITS+1];
  logic [NUM_W-1:0] num_r [QBITS+1];
  logic [MAG_W-1:0] den_r [QBITS+1];
  logic [QBITS-1:0] q_r   [QBITS+1];
  logic             ovf_r [QBITS+1];
  logic             neg_r [QBITS+1];
  logic             sng_r [QBITS+1];
  logic             v_r   [QBITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= QBITS; s++) v_r[s] <= 1'b0;
    end else if (en) begin
      v_r[0] <= vin;
      for (int s = 1; s <= QBITS; s++) v_r[s] <= v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // initial remainder: top bits of the numerator above the QBITS window
      rem_r[0] <= REM_W'({32'd0, amag} >> 1);
      num_r[0] <= {amag, 32'd0} & NUM_W'({QBITS{1'b1}});
      den_r[0] <= den;
      q_r[0]   <= '0;
      ovf_r[0] <= ({33'd0, amag} >= {den, 1'b0}) && !sing;
      neg_r[0] <= neg;
      sng_r[0] <= sing;
      for (int s = 1; s <= QBITS; s++) begin
        logic [REM_W-1:0] t;
        t = {rem_r[s-1][REM_W-2:0], num_r[s-1][QBITS-s]};
        if (t >= REM_W'(den_r[s-1])) begin
          rem_r[s] <= t - REM_W'(den_r[s-1]);
          q_r[s]   <= q_r[s-1] | (QBITS'(1) << (QBITS-s));
        end else begin
          rem_r[s] <= t;
          q_r[s]   <= q_r[s-1];
        end
        num_r[s] <= num_r[s-1];
        den_r[s] <= den_r[s-1];
        ovf_r[s] <= ovf_r[s-1];
        neg_r[s] <= neg_r[s-1];
        sng_r[s] <= sng_r[s-1];
      end
    end
  end

  logic [QBITS-1:0] qf;
  logic             big;
  assign qf  = q_r[QBITS];
  assign big = ovf_r[QBITS] ||
               (neg_r[QBITS] ? (qf > QBITS'(33'h80000000)) :
                               (qf > QBITS'(33'h7fffffff)));

  always_comb begin
    if (sng_r[QBITS]) begin
      q = '0; sat = 1'b0;
    end else if (big) begin
      q   = neg_r[QBITS] ? elem_t'(32'h80000000) : elem_t'(32'h7fffffff);
      sat = 1'b1;
    end else begin
      q   = neg_r[QBITS] ? elem_t'(-qf[31:0]) : elem_t'(qf[31:0]);
      sat = 1'b0;
    end
  end

  assign vout = v_r[QBITS];

endmodule

// File: rtl/matrix3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3_inverse: 3x3 Q16.16 matrix inverse by the adjugate
// channel | dir | tdata fields (low bit up)
// in_     | in  | r0c0..r2c2, 9 x 32b signed
// out_    | out | inv_r0c0..inv_r2c2 (288b); tuser: singular, saturated
// One matrix per cycle unless stalled, via cofactor, divider and output
// register. The whole pipeline advances when the output register is empty
// or taken; a stall freezes every stage. Reset clears valid bits.
// ----------------------------------------------------------------------------
module matrix3_inverse
  import m3inv_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [287:0] in_tdata,    // r0c0, r0c1, r0c2, r1c0, .. r2c2
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [287:0] out_tdata,   // inv_r0c0 .. inv_r2c2
  output logic [1:0]   out_tuser    // singular, saturated
);

  logic        en, cv;
  elem_t [8:0] m;
  logic [MAG_W-1:0] dmag;
  logic [63:0] amag [9];
  ctl_t        ctl;
  logic [8:0]  dv, dsat;
  elem_t       q [9];
  logic        sng_d;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign m         = in_tdata;

  m3inv_cof u_cof (
    .clk, .rst_n, .en, .vin(in_tvalid),
    .m, .vout(cv), .dmag, .amag, .ctl
  );

  // singular flag rides alongside the divider lanes
  logic [QBITS:0] sd_r;
  always_ff @(posedge clk) begin
    if (en) sd_r <= {sd_r[QBITS-1:0], ctl.sing};
  end
  assign sng_d = sd_r[QBITS];

  for (genvar i = 0; i < 9; i++) begin : g_div
    m3inv_div u_div (
      .clk, .rst_n, .en, .vin(cv), .den(dmag), .amag(amag[i]),
      .neg(ctl.neg[i]), .sing(ctl.sing),
      .vout(dv[i]), .q(q[i]), .sat(dsat[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (en) begin
      out_tvalid <= dv[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) out_tdata[32*i +: 32] <= q[i];
      out_tuser <= {|dsat, sng_d};
    end
  end

endmodule

// File: tb/matrix3_inverse_tb.sv
// ----------------------------------------------------------------------------
// matrix3_inverse_tb: self-checking bench for the 3x3 Q16.16 matrix inverse
// Drives matrices through the input stream and compares every result with a
// bit-exact adjugate predictor. Directed table first, then random matrices
// with random bursts of idle cycles on both sides.
// ----------------------------------------------------------------------------
module matrix3_inverse_tb;

  localparam int N_RAND    = 1250;
  localparam int MAX_CYC   = 400000;
  localparam int DRAIN_CYC = 60;
  localparam int N_DIR     = 14;

  typedef struct {
    logic [287:0] data;
    logic [1:0]   flags;   // bit0 singular, bit1 saturated
  } inv_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [287:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [287:0] out_tdata;
  logic [1:0]   out_tuser;

  inv_res_t inv_q[$];
  int       n_err = 0;
  int       n_tab = 0;
  int       n_got = 0;
  int       n_sing = 0;
  int       n_sat = 0;
  int       cyc = 0;
  bit       calm = 1'b0;

  always #4 clk = ~clk;

  matrix3_inverse u_top (.*);

  // exact adjugate inverse, truncated toward zero, saturating
  function automatic inv_res_t inverse_of(logic [287:0] m);
    logic signed [127:0] x[9];
    logic signed [127:0] adj[9];
    logic signed [127:0] det;
    logic [127:0] dmag, num, q;
    logic [31:0] v;
    logic neg, sat;
    inv_res_t r;
    for (int i = 0; i < 9; i++) x[i] = $signed(m[i*32 +: 32]);
    adj[0] = x[4]*x[8] - x[5]*x[7];
    adj[1] = x[2]*x[7] - x[1]*x[8];
    adj[2] = x[1]*x[5] - x[2]*x[4];
    adj[3] = x[5]*x[6] - x[3]*x[8];
    adj[4] = x[0]*x[8] - x[2]*x[6];
    adj[5] = x[2]*x[3] - x[0]*x[5];
    adj[6] = x[3]*x[7] - x[4]*x[6];
    adj[7] = x[6]*x[1] - x[0]*x[7];
    adj[8] = x[0]*x[4] - x[1]*x[3];
    det = x[0]*adj[0] + x[1]*adj[3] + x[2]*adj[6];
    r.data = '0;
    r.flags = 2'b01;
    if (det == 0) return r;
    sat = 1'b0;
    dmag = det < 0 ? -det : det;
    for (int i = 0; i < 9; i++) begin
      num = (adj[i] < 0 ? -adj[i] : adj[i]) << 32;
      q = num / dmag;
      neg = (adj[i] < 0) != (det < 0);
      if (neg) begin
        if (q > 128'h8000_0000) begin
          q = 128'h8000_0000;
          sat = 1'b1;
        end
        v = 32'(-q);
      end else begin
        if (q > 128'h7FFF_FFFF) begin
          q = 128'h7FFF_FFFF;
          sat = 1'b1;
        end
        v = q[31:0];
      end
      r.data[i*32 +: 32] = v;
    end
    r.flags = {sat, 1'b0};
    return r;
  endfunction

  function automatic logic [287:0] pack_mat(logic [31:0] a, b, c, d, e, f, g, h, k);
    return {k, h, g, f, e, d, c, b, a};
  endfunction

  // mix of magnitudes so both ordinary and clipped results show up
  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
      2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(0, 262144)) - 131072) <<< 2;
    endcase
  endfunction

  function automatic logic [287:0] rand_mat();
    logic [287:0] m;
    for (int i = 0; i < 9; i++) m[i*32 +: 32] = rand_elem();
    // occasionally copy a row so the determinant is zero
    if ($urandom_range(0, 9) == 0) m[96 +: 96] = m[0 +: 96];
    return m;
  endfunction

  task automatic send_matrix(logic [287:0] m);
    inv_q.push_back(inverse_of(m));
    in_tvalid <= 1'b1;
    in_tdata  <= m;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // receiver with random stall bursts
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 13) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    inv_res_t exp_r;
    cyc <= cyc + 1;
    if (rst_n && out_tvalid && out_tready) begin
      n_got <= n_got + 1;
      if (inv_q.size() == 0) begin
        n_err <= n_err + 1;
        if (n_err < 10) $display("unexpected result %h", out_tdata);
      end else begin
        exp_r = inv_q.pop_front();
        if (exp_r.flags[0]) n_sing <= n_sing + 1;
        if (exp_r.flags[1]) n_sat <= n_sat + 1;
        if (out_tdata !== exp_r.data || out_tuser !== exp_r.flags) begin
          n_err <= n_err + 1;
          if (n_err < 10)
            $display("mismatch: exp %h/%b got %h/%b", exp_r.data, exp_r.flags,
                     out_tdata, out_tuser);
        end
      end
    end
    if (cyc > MAX_CYC) begin
      $display("timeout after %0d cycles", cyc);
      $display("matrix3_inverse_tb: FAIL");
      $finish;
    end
  end

  initial begin
    logic [287:0] dir_mat[N_DIR];
    logic [287:0] want[N_DIR];
    logic [1:0]   want_flags[N_DIR];
    bit           typed[N_DIR];
    logic [31:0]  one, neg1, two, mx, mn;
    one = 32'h0001_0000; neg1 = 32'hFFFF_0000; two = 32'h0002_0000;
    mx = 32'h7FFF_FFFF; mn = 32'h8000_0000;
    for (int i = 0; i < N_DIR; i++) typed[i] = 1'b0;
    // identity: inverse is identity
    dir_mat[0] = pack_mat(one, 0, 0, 0, one, 0, 0, 0, one);
    want[0] = dir_mat[0]; want_flags[0] = 2'b00; typed[0] = 1'b1;
    // all zero: singular
    dir_mat[1] = '0; want[1] = '0; want_flags[1] = 2'b01; typed[1] = 1'b1;
    // all ones: singular
    dir_mat[2] = {288{1'b1}}; want[2] = '0; want_flags[2] = 2'b01; typed[2] = 1'b1;
    // minus identity
    dir_mat[3] = pack_mat(neg1, 0, 0, 0, neg1, 0, 0, 0, neg1);
    want[3] = dir_mat[3]; want_flags[3] = 2'b00; typed[3] = 1'b1;
    // tiny diagonal: every diagonal element clips
    dir_mat[4] = pack_mat(32'd1, 0, 0, 0, 32'd1, 0, 0, 0, 32'hFFFF_FFFF);
    want[4] = pack_mat(mx, 0, 0, 0, mx, 0, 0, 0, mn); want_flags[4] = 2'b10;
    typed[4] = 1'b1;
    dir_mat[5] = pack_mat(mx, 0, 0, 0, mx, 0, 0, 0, mx);
    dir_mat[6] = pack_mat(mn, 0, 0, 0, mn, 0, 0, 0, mn);
    dir_mat[7] = pack_mat(mn, mx, mn, mx, mn, mx, mn, mx, mx);
    dir_mat[8] = pack_mat(two, one, 0, one, two, one, 0, one, two);
    dir_mat[9] = pack_mat(0, one, 0, 0, 0, one, one, 0, 0);
    dir_mat[10] = pack_mat(mx, mx, 0, mn, 0, mx, 0, mn, mn);
    dir_mat[11] = pack_mat(32'd3, 32'd1, 0, 0, 32'd7, 0, 32'd1, 0, 32'd5);
    dir_mat[12] = pack_mat(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678,
                           32'hFEDC_BA98, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                           32'h0000_FFFF, 32'hFFFF_0001, 32'h7000_0000);
    dir_mat[13] = pack_mat(one, two, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000,
                           32'h0006_0000, 32'h0007_0000, 32'h0008_0000,
                           32'h000A_0000);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < N_DIR; i++) begin
      if (typed[i] && (inverse_of(dir_mat[i]).data !== want[i] ||
                       inverse_of(dir_mat[i]).flags !== want_flags[i])) begin
        n_tab++;
        $display("directed row %0d: predictor disagrees with table", i);
      end
      send_matrix(dir_mat[i]);
    end
    for (int i = 0; i < N_RAND; i++) begin
      if (i == N_RAND / 2) begin
        // hold off until the pipeline has drained completely
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (inv_q.size() != 0) @(posedge clk);
      end
      if (i == N_RAND - 150) calm = 1'b1;
      send_matrix(rand_mat());
    end
    in_tvalid <= 1'b0;
    while (inv_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    $display("covered %0d matrices: %0d singular, %0d with clipped elements",
             n_got, n_sing, n_sat);
    if (n_err + n_tab == 0) begin
      $display("matrix3_inverse_tb: PASS");
    end else begin
      $display("%0d mismatches", n_err + n_tab);
      $display("matrix3_inverse_tb: FAIL");
    end
    $finish;
  end

endmodule
